/* hdl/sfb_pkg.sv */
// ----------------------------------------------------------------------------
// sfb_pkg
// Shared types and constants for the sum-checked frame builder.
// ----------------------------------------------------------------------------
package sfb_pkg;

   localparam logic [7:0] HDR0_BYTE       = 8'hAA;
   localparam logic [7:0] HDR1_BYTE       = 8'h55;
   localparam logic [7:0] TRL0_BYTE       = 8'h0D;
   localparam logic [7:0] TRL1_BYTE       = 8'h0A;
   localparam logic [7:0] LEN_HIGH_BYTE   = 8'h00;
   localparam logic [7:0] LENGTH_RESET    = 8'd128;

   localparam int QUEUE_DEPTH_DEFAULT = 4;

   // Output sequence of one frame; a descriptor covers a slice of it.
   localparam logic [2:0] PH_HDR0    = 3'd0;
   localparam logic [2:0] PH_HDR1    = 3'd1;
   localparam logic [2:0] PH_LEN_LO  = 3'd2;
   localparam logic [2:0] PH_LEN_HI  = 3'd3;
   localparam logic [2:0] PH_PAYLOAD = 3'd4;
   localparam logic [2:0] PH_CSUM    = 3'd5;
   localparam logic [2:0] PH_TRL0    = 3'd6;
   localparam logic [2:0] PH_TRL1    = 3'd7;

   typedef struct packed {
      logic       first;
      logic       last;
      logic [7:0] payload;
      logic [7:0] csum;
      logic [7:0] len;
   } desc_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

/* hdl/sfb_front.sv */
// ----------------------------------------------------------------------------
// sfb_front
// Accepts payload bytes, tracks frame position and running sum, and builds
// one descriptor per byte for the back end.
// ----------------------------------------------------------------------------
module sfb_front
   import sfb_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_write_enable,
   input  logic [7:0] csr_write_data,
   input  logic       req_valid,
   input  logic [7:0] req_payload_byte,
   input  logic       accept,
   output desc_type   desc
);

   logic [7:0] payload_length_ff;
   logic [7:0] byte_position_ff;
   logic [7:0] byte_position_in;
   logic [7:0] running_sum_ff;
   logic [7:0] running_sum_in;
   logic [7:0] eff_len;
   logic [7:0] sum_next;
   logic [8:0] pos_plus_one;
   logic       is_last;

   always_comb begin
      eff_len      = (payload_length_ff == 8'd0) ? 8'd1 : payload_length_ff;
      pos_plus_one = {1'b0, byte_position_ff} + 9'd1;
      is_last      = pos_plus_one >= {1'b0, eff_len};
      sum_next     = running_sum_ff + req_payload_byte;

      desc.first   = (byte_position_ff == 8'd0);
      desc.last    = is_last;
      desc.payload = req_payload_byte;
      desc.csum    = sum_next;
      desc.len     = eff_len;

      byte_position_in = byte_position_ff;
      running_sum_in   = running_sum_ff;
      if (accept && req_valid) begin
         if (is_last) begin
            byte_position_in = 8'd0;
            running_sum_in   = 8'd0;
         end else begin
            byte_position_in = pos_plus_one[7:0];
            running_sum_in   = sum_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         payload_length_ff <= LENGTH_RESET;
         byte_position_ff  <= 8'd0;
         running_sum_ff    <= 8'd0;
      end else begin
         if (csr_write_enable) begin
            payload_length_ff <= csr_write_data;
         end
         byte_position_ff <= byte_position_in;
         running_sum_ff   <= running_sum_in;
      end
   end

endmodule

/* hdl/sfb_queue.sv */
// ----------------------------------------------------------------------------
// sfb_queue
// Small descriptor FIFO between the front and back ends.
// ----------------------------------------------------------------------------
module sfb_queue
   import sfb_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEFAULT
)
(
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  desc_type         push_data,
   input  logic             pop,
   output desc_type         head,
   output queue_status_type status
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   desc_type         entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_in;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             do_push;
   logic             do_pop;

   always_comb begin
      status.full  = (count_ff == FULL_CNT);
      status.empty = (count_ff == '0);
      do_push      = push && !status.full;
      do_pop       = pop && !status.empty;
      head         = entry_ff[rd_ptr_ff];

      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

/* hdl/sfb_back.sv */
// ----------------------------------------------------------------------------
// sfb_back
// Expands each descriptor into its output bytes and emits them into an output
// register, one per cycle while that register is free.
// ----------------------------------------------------------------------------
module sfb_back
   import sfb_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  desc_type   head,
   input  logic       head_valid,
   output logic       pop,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_tx_byte,
   output logic       rsp_run_last,
   output logic       rsp_frame_last
);

   logic       started_ff;
   logic       started_in;
   logic [2:0] phase_ff;
   logic [2:0] phase_in;
   logic [2:0] phase;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic [7:0] tx_byte_ff;
   logic       run_last_ff;
   logic       frame_last_ff;
   logic [7:0] sel_byte;
   logic       slot_free;
   logic       emit;
   logic       done;

   always_comb begin
      if (started_ff) begin
         phase = phase_ff;
      end else begin
         phase = head.first ? PH_HDR0 : PH_PAYLOAD;
      end

      unique case (phase)
         PH_HDR0:    sel_byte = HDR0_BYTE;
         PH_HDR1:    sel_byte = HDR1_BYTE;
         PH_LEN_LO:  sel_byte = head.len;
         PH_LEN_HI:  sel_byte = LEN_HIGH_BYTE;
         PH_PAYLOAD: sel_byte = head.payload;
         PH_CSUM:    sel_byte = head.csum;
         PH_TRL0:    sel_byte = TRL0_BYTE;
         PH_TRL1:    sel_byte = TRL1_BYTE;
         default:    sel_byte = head.payload;
      endcase

      done      = (phase == PH_TRL1) || ((phase == PH_PAYLOAD) && !head.last);
      slot_free = !rsp_valid_ff || !rsp_stall;
      emit      = head_valid && slot_free;
      pop       = emit && done;

      started_in = started_ff;
      phase_in   = phase_ff;
      if (emit) begin
         started_in = !done;
         phase_in   = phase + 3'd1;
      end

      // Drop the register once taken, refill when a byte is emitted.
      rsp_valid_in = rsp_valid_ff;
      if (slot_free) begin
         rsp_valid_in = emit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff   <= 1'b0;
         phase_ff     <= PH_HDR0;
         rsp_valid_ff <= 1'b0;
      end else begin
         started_ff   <= started_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         tx_byte_ff    <= sel_byte;
         run_last_ff   <= done;
         frame_last_ff <= (phase == PH_TRL1);
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_tx_byte    = tx_byte_ff;
   assign rsp_run_last   = run_last_ff;
   assign rsp_frame_last = frame_last_ff;

endmodule

/* hdl/sum_checked_frame_builder_top.sv */
// Payload bytes pass through the descriptor queue and the output register.
// One output byte per cycle while the queue is not empty and rsp_stall does
// not hold the output; a frame's first byte adds header and length, its last checksum and trailer.
// Input is taken every cycle while the descriptor queue has room.
// Reset (synchronous, active high) empties the queue, restarts the frame and
// sets the payload length to 128.
// ----------------------------------------------------------------------------
// sum_checked_frame_builder_top
// Wraps payload bytes into frames with header, length, checksum and trailer.
// ----------------------------------------------------------------------------
module sum_checked_frame_builder_top
   import sfb_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
)
(
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_write_enable,
   input  logic [7:0] csr_write_data,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_payload_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_tx_byte,
   output logic       rsp_run_last,
   output logic       rsp_frame_last
);

   desc_type         front_desc;
   desc_type         queue_head;
   queue_status_type queue_status;
   logic             accept;
   logic             pop;

   assign req_stall = queue_status.full;
   assign accept    = req_valid && !queue_status.full;

   sfb_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_payload_byte (req_payload_byte),
      .accept           (accept),
      .desc             (front_desc)
   );

   sfb_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_data (front_desc),
      .pop       (pop),
      .head      (queue_head),
      .status    (queue_status)
   );

   sfb_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head           (queue_head),
      .head_valid     (!queue_status.empty),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_tx_byte    (rsp_tx_byte),
      .rsp_run_last   (rsp_run_last),
      .rsp_frame_last (rsp_frame_last)
   );

endmodule

/* sim/sum_checked_frame_builder_checker.sv */
// ----------------------------------------------------------------------------
// sum_checked_frame_builder_checker
// Watches the payload, result and register ports of the frame builder, keeps
// its own copy of the framing state and compares every output byte in order.
// ----------------------------------------------------------------------------
module sum_checked_frame_builder_checker
   import sfb_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_write_enable,
   input  logic [7:0] csr_write_data,
   input  logic       req_valid,
   input  logic       req_stall,
   input  logic [7:0] req_payload_byte,
   input  logic       rsp_valid,
   input  logic       rsp_stall,
   input  logic [7:0] rsp_tx_byte,
   input  logic       rsp_run_last,
   input  logic       rsp_frame_last,
   output int         pending_count,
   output int         mismatch_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [7:0] tx_byte;
      logic       run_last;
      logic       frame_last;
   } frame_byte_type;

   frame_byte_type framed_bytes_q[$];
   logic [7:0]     frame_length;
   logic [7:0]     payload_index;
   logic [7:0]     payload_sum;

   function automatic void append_frame_byte(input logic [7:0] value, input logic closes);
      framed_bytes_q.push_back('{value, 1'b0, closes});
   endfunction

   // Expand one payload byte into the framed bytes it produces.
   function automatic void frame_payload_byte(input logic [7:0] data);
      logic [7:0]     eff_length;
      frame_byte_type tail;
      eff_length = (frame_length == 8'd0) ? 8'd1 : frame_length;
      if (payload_index == 8'd0) begin
         append_frame_byte(HDR0_BYTE, 1'b0);
         append_frame_byte(HDR1_BYTE, 1'b0);
         append_frame_byte(eff_length, 1'b0);
         append_frame_byte(LEN_HIGH_BYTE, 1'b0);
      end
      append_frame_byte(data, 1'b0);
      payload_sum = payload_sum + data;
      // A shortened length closes the frame at once.
      if ({1'b0, payload_index} + 9'd1 >= {1'b0, eff_length}) begin
         append_frame_byte(payload_sum, 1'b0);
         append_frame_byte(TRL0_BYTE, 1'b0);
         append_frame_byte(TRL1_BYTE, 1'b1);
         payload_index = 8'd0;
         payload_sum = 8'd0;
      end else begin
         payload_index = payload_index + 8'd1;
      end
      tail = framed_bytes_q.pop_back();
      tail.run_last = 1'b1;
      framed_bytes_q.push_back(tail);
   endfunction

   function automatic void note_mismatch(input string field, input logic [7:0] want,
                                         input logic [7:0] got);
      mismatch_count++;
      $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
   endfunction

   always @(posedge clock) begin
      frame_byte_type want;
      if (reset) begin
         framed_bytes_q.delete();
         frame_length = LENGTH_RESET;
         payload_index = 8'd0;
         payload_sum = 8'd0;
         mismatch_count = 0;
      end else begin
         if (csr_write_enable) begin
            frame_length = csr_write_data;
         end
         if (req_valid && !req_stall) begin
            frame_payload_byte(req_payload_byte);
         end
         if (rsp_valid && !rsp_stall) begin
            if (framed_bytes_q.size() == 0) begin
               mismatch_count++;
               $display("%0t: unexpected transaction, expected none, got %h %b %b",
                        $time, rsp_tx_byte, rsp_run_last, rsp_frame_last);
            end else begin
               want = framed_bytes_q.pop_front();
               if (want.tx_byte !== rsp_tx_byte) begin
                  note_mismatch("tx_byte", want.tx_byte, rsp_tx_byte);
               end
               if (want.run_last !== rsp_run_last) begin
                  note_mismatch("run_last", {7'd0, want.run_last}, {7'd0, rsp_run_last});
               end
               if (want.frame_last !== rsp_frame_last) begin
                  note_mismatch("frame_last", {7'd0, want.frame_last}, {7'd0, rsp_frame_last});
               end
            end
         end
      end
      pending_count = framed_bytes_q.size();
   end

endmodule

/* sim/tb_sum_checked_frame_builder_top.sv */
// ----------------------------------------------------------------------------
// tb_sum_checked_frame_builder_top
// Drives payload bytes and length settings into the frame builder under
// varying sender gaps and receiver stalls; the checker judges every byte.
// ----------------------------------------------------------------------------
module tb_sum_checked_frame_builder_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam real CLOCK_PERIOD  = 12.0;
   localparam int  RESET_CYCLES  = 10;
   localparam int  SETTLE_CYCLES = 4;
   localparam int  HOLD_CYCLES   = 300;
   localparam int  CYCLE_LIMIT   = 400000;

   typedef enum int {
      IDLE_NONE,
      IDLE_SENDER,
      IDLE_RECEIVER,
      IDLE_BOTH
   } idle_mode_type;

   logic       clock = 1'b0;
   logic       reset;
   logic       csr_write_enable;
   logic [7:0] csr_write_data;
   logic       req_valid;
   logic       req_stall;
   logic [7:0] req_payload_byte;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_tx_byte;
   logic       rsp_run_last;
   logic       rsp_frame_last;

   int         pending_count;
   int         mismatch_count;
   int         send_idle_pct;
   int         stall_pct = 0;
   logic       long_hold = 1'b0;
   int         hold_count;
   int         cycle_count = 0;

   always #(CLOCK_PERIOD / 2.0) clock = ~clock;

   sum_checked_frame_builder_top dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_payload_byte (req_payload_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_tx_byte      (rsp_tx_byte),
      .rsp_run_last     (rsp_run_last),
      .rsp_frame_last   (rsp_frame_last)
   );

   sum_checked_frame_builder_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_payload_byte (req_payload_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_tx_byte      (rsp_tx_byte),
      .rsp_run_last     (rsp_run_last),
      .rsp_frame_last   (rsp_frame_last),
      .pending_count    (pending_count),
      .mismatch_count   (mismatch_count)
   );

   // Receiver: one long hold-off when requested, random stalls otherwise.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_count <= 0;
      end else if (long_hold && hold_count < HOLD_CYCLES) begin
         rsp_stall <= 1'b1;
         hold_count <= hold_count + 1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_sum_checked_frame_builder_top: FAIL");
         $finish;
      end
   end

   task automatic set_idle(input idle_mode_type mode);
      unique case (mode)
         IDLE_NONE: begin
            send_idle_pct = 0;
            stall_pct <= 0;
         end
         IDLE_SENDER: begin
            send_idle_pct = 57;
            stall_pct <= 0;
         end
         IDLE_RECEIVER: begin
            send_idle_pct = 0;
            stall_pct <= 57;
         end
         default: begin
            send_idle_pct = 28;
            stall_pct <= 28;
         end
      endcase
   endtask

   task automatic send_byte(input logic [7:0] value);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         req_payload_byte <= 8'($urandom);
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload_byte <= value;
      do @(posedge clock); while (req_stall);
   endtask

   // Stop sending and wait for every framed byte to come out.
   task automatic drain_stream();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending_count != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_length(input logic [7:0] length);
      csr_write_enable <= 1'b1;
      csr_write_data <= length;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic run_phase(input logic [7:0] length, input int count,
                            input idle_mode_type mode, input logic with_hold,
                            input int pause_at);
      drain_stream();
      write_length(length);
      set_idle(mode);
      long_hold <= with_hold;
      for (int i = 0; i < count; i++) begin
         if (i == pause_at) begin
            drain_stream();
         end
         send_byte(8'($urandom));
      end
      long_hold <= 1'b0;
   endtask

   initial begin
      reset <= 1'b1;
      csr_write_enable <= 1'b0;
      csr_write_data <= 8'd0;
      req_valid <= 1'b0;
      req_payload_byte <= 8'd0;
      send_idle_pct = 0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed: default length, then a frame cut short by a new length.
      set_idle(IDLE_BOTH);
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(8'h5A);
      drain_stream();
      write_length(8'd2);
      send_byte(8'hA5);
      // Zero length acts as one: a full frame per byte.
      drain_stream();
      write_length(8'd0);
      send_byte(8'h01);
      send_byte(8'hFE);
      drain_stream();
      write_length(8'd1);
      send_byte(8'hFF);
      send_byte(8'h00);
      // Checksum wraps past 8 bits.
      drain_stream();
      write_length(8'd3);
      send_byte(8'hFF);
      send_byte(8'hFF);
      send_byte(8'hFF);
      drain_stream();
      write_length(8'd2);
      send_byte(8'h80);
      send_byte(8'h7F);
      send_byte(8'h55);
      send_byte(8'hAA);
      drain_stream();
      write_length(8'd1);
      send_byte(8'hC3);

      // Random: one full maximum-length frame, then mostly short frames.
      run_phase(8'd255, 255, IDLE_SENDER, 1'b0, -1);
      run_phase(8'd1, 30, IDLE_RECEIVER, 1'b0, -1);
      run_phase(8'd3, 40, IDLE_NONE, 1'b1, -1);
      run_phase(8'd7, 40, IDLE_BOTH, 1'b0, 20);
      run_phase(8'd0, 20, IDLE_RECEIVER, 1'b0, -1);
      run_phase(8'd128, 40, IDLE_NONE, 1'b0, -1);
      run_phase(8'd2, 30, IDLE_BOTH, 1'b0, -1);
      run_phase(8'($urandom_range(1, 12)), 30, IDLE_SENDER, 1'b0, -1);

      drain_stream();
      if (mismatch_count == 0) begin
         $display("tb_sum_checked_frame_builder_top: PASS");
      end else begin
         $display("tb_sum_checked_frame_builder_top: FAIL");
      end
      $finish;
   end

endmodule

/* sim.f */
hdl/sfb_pkg.sv
hdl/sfb_front.sv
hdl/sfb_queue.sv
hdl/sfb_back.sv
hdl/sum_checked_frame_builder_top.sv
sim/sum_checked_frame_builder_checker.sv
sim/tb_sum_checked_frame_builder_top.sv
